[hdl/fan_tach_rpm_meter_assert.svh]
// Assertion macros used by the fan tachometer speed meter controller.
`ifndef FAN_TACH_RPM_METER_ASSERT_SVH
`define FAN_TACH_RPM_METER_ASSERT_SVH

`ifndef ASSERT_OFF
// Check a property on the rising clock edge, ignored while reset is high.
`define FTRM_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("fan_tach_rpm_meter: assertion failed");
// Check a property on every rising clock edge, reset included.
`define FTRM_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("fan_tach_rpm_meter: assertion failed");
`else
`define FTRM_ASSERT(label, clk, rst, prop)
`define FTRM_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

[hdl/ftrm_pkg.sv]
// Package: widths, register indexes, reset values and controller types.
`default_nettype none

package ftrm_pkg;

   localparam int unsigned RING_DEPTH_DEF = 8;

   localparam int unsigned CAPTURE_W  = 16;
   localparam int unsigned TICKS_W    = 48;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned RPM_W      = 32;
   localparam int unsigned CSR_IDX_W  = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CLOCKS_PER_RPM = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_PULSE     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STALL          = 2'd2;

   // register reset values
   localparam logic [CSR_DATA_W-1:0] CLOCKS_PER_RPM_RST = 32'd39375000;
   localparam logic [CSR_DATA_W-1:0] LONG_PULSE_RST     = 32'd8355840;
   localparam logic [CSR_DATA_W-1:0] STALL_RST          = 32'd1000000;

   // item command codes
   localparam logic CMD_CAPTURE = 1'b0;
   localparam logic CMD_READ    = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ELAPSED,
      ST_CHECK,
      ST_SUM,
      ST_MUL,
      ST_DIV,
      ST_FINISH
   } ftrm_state_type;

   typedef struct packed {
      logic load;         // latch the accepted word
      logic elapsed;      // register time since last pulse
      logic commit;       // store a capture interval
      logic clear;        // drop every ring entry
      logic sum_start;    // reset the ring sweep
      logic sum_step;     // advance the ring sweep
      logic mul;          // form the dividend
      logic div_step;     // one quotient bit
      logic result_load;  // fill the result register
   } ftrm_cmd_type;

   typedef struct packed {
      logic is_read;
      logic over_stall;
      logic sum_last;
      logic div_last;
   } ftrm_status_type;

endpackage

`default_nettype wire

[hdl/ftrm_if.sv]
// Channel interfaces: request, result and register write.
`default_nettype none

interface ftrm_req_if import ftrm_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 cmd;
   logic [CAPTURE_W-1:0] capture_value;
   logic                 over_capture;
   logic [TICKS_W-1:0]   now_ticks;

   modport source (output valid, cmd, capture_value, over_capture, now_ticks, input ready);
   modport sink   (input valid, cmd, capture_value, over_capture, now_ticks, output ready);
endinterface

interface ftrm_rsp_if import ftrm_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [RPM_W-1:0] rpm;
   logic             stalled;

   modport source (output valid, rpm, stalled, input ready);
   modport sink   (input valid, rpm, stalled, output ready);
endinterface

interface ftrm_csr_if import ftrm_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hdl/ftrm_ctrl.sv]
// Controller: sequences one word through elapsed check, ring sweep and divide.
`default_nettype none
`include "fan_tach_rpm_meter_assert.svh"

module ftrm_ctrl import ftrm_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  ftrm_status_type status,
   output ftrm_cmd_type    cmd
);

   ftrm_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_ELAPSED;
         end
         ST_ELAPSED: state_in = ST_CHECK;
         ST_CHECK: begin
            if (status.is_read && !status.over_stall) state_in = ST_SUM;
            else state_in = ST_FINISH;
         end
         ST_SUM: begin
            if (status.sum_last) state_in = ST_MUL;
         end
         ST_MUL: state_in = ST_DIV;
         ST_DIV: begin
            if (status.div_last) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE:    cmd.load = req_valid;
         ST_ELAPSED: cmd.elapsed = 1'b1;
         ST_CHECK: begin
            priority if (!status.is_read) cmd.commit = 1'b1;
            else if (status.over_stall) cmd.clear = 1'b1;
            else cmd.sum_start = 1'b1;
         end
         ST_SUM:     cmd.sum_step = 1'b1;
         ST_MUL:     cmd.mul = 1'b1;
         ST_DIV:     cmd.div_step = 1'b1;
         ST_FINISH:  cmd.result_load = slot_free;
         default:    cmd = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.result_load) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `FTRM_ASSERT(a_accept_starts, clock, reset, (req_valid && req_ready) |=> (state_ff == ST_ELAPSED))
   `FTRM_ASSERT(a_sweep_to_mul, clock, reset, (state_ff == ST_SUM && status.sum_last) |=> (state_ff == ST_MUL))
   `FTRM_ASSERT(a_finish_waits, clock, reset, (state_ff == ST_FINISH && !slot_free) |=> (state_ff == ST_FINISH))
   `FTRM_ASSERT_ALWAYS(a_rsp_from_finish, clock, $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))

endmodule

`default_nettype wire

[hdl/ftrm_dpath.sv]
// Datapath: registers, interval ring, ring sweep adder and serial divider.
`default_nettype none

module ftrm_dpath import ftrm_pkg::*; #(
   parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ftrm_cmd_type          cmd,
   output ftrm_status_type       status,
   input  logic                  req_cmd,
   input  logic [CAPTURE_W-1:0]  req_capture_value,
   input  logic                  req_over_capture,
   input  logic [TICKS_W-1:0]    req_now_ticks,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output logic [RPM_W-1:0]      rsp_rpm,
   output logic                  rsp_stalled
);

   localparam int unsigned ADDR_W = $clog2(RING_DEPTH);
   localparam int unsigned CNT_W  = $clog2(RING_DEPTH + 1);
   localparam int unsigned SUM_W  = CAPTURE_W + CNT_W;
   localparam int unsigned PROD_W = CSR_DATA_W + CNT_W;
   localparam int unsigned STEP_W = $clog2(PROD_W);

   // configuration
   logic [CSR_DATA_W-1:0] cpr_ff, long_ff, stall_ff;
   // latched word
   logic                  cmd_ff, ovf_ff;
   logic [CAPTURE_W-1:0]  cap_ff;
   logic [TICKS_W-1:0]    now_ff;
   // meter state
   logic [CAPTURE_W-1:0]  prev_cap_ff, prev_cap_in;
   logic [TICKS_W-1:0]    last_pulse_ff, last_pulse_in;
   logic [ADDR_W-1:0]     ptr_ff, ptr_in;
   logic [RING_DEPTH-1:0] valid_ff, valid_in;
   logic [CAPTURE_W-1:0]  ring_mem [RING_DEPTH];
   logic [TICKS_W-1:0]    elapsed_ff;
   // sweep
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic [CAPTURE_W-1:0]  rd_data_ff;
   logic                  rd_hit_ff, rd_hit_in;
   logic [SUM_W-1:0]      acc_ff, acc_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   // divider
   logic [SUM_W-1:0]      rem_ff, rem_in;
   logic [PROD_W-1:0]     quo_ff, quo_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   // result
   logic [RPM_W-1:0]      rpm_ff, rpm_in;
   logic                  stalled_ff, stalled_in;

   logic                  over_long, over_stall;
   logic [CAPTURE_W-1:0]  diff, wr_data;
   logic                  store;
   logic                  rd_en;
   logic [ADDR_W-1:0]     rd_addr;
   logic [SUM_W:0]        shifted, trial;
   logic                  ge;

   assign over_long  = (elapsed_ff[TICKS_W-1:CSR_DATA_W] != '0)
                     || (elapsed_ff[CSR_DATA_W-1:0] > long_ff);
   assign over_stall = (elapsed_ff[TICKS_W-1:CSR_DATA_W] != '0)
                     || (elapsed_ff[CSR_DATA_W-1:0] > stall_ff);
   assign diff    = cap_ff - prev_cap_ff;
   assign wr_data = over_long ? '0 : diff;
   assign store   = cmd.commit && !ovf_ff;

   assign rd_en   = cmd.sum_step && (idx_ff < CNT_W'(RING_DEPTH));
   assign rd_addr = idx_ff[ADDR_W-1:0];

   assign shifted = {rem_ff, quo_ff[PROD_W-1]};
   assign trial   = shifted - {1'b0, acc_ff};
   assign ge      = (shifted >= {1'b0, acc_ff});

   assign status.is_read    = (cmd_ff == CMD_READ);
   assign status.over_stall = over_stall;
   assign status.sum_last   = (idx_ff == CNT_W'(RING_DEPTH));
   assign status.div_last   = (step_ff == STEP_W'(PROD_W - 1));

   assign rsp_rpm     = rpm_ff;
   assign rsp_stalled = stalled_ff;

   // configuration registers; unknown indexes drop the write
   always_ff @(posedge clock) begin
      if (reset) begin
         cpr_ff   <= CLOCKS_PER_RPM_RST;
         long_ff  <= LONG_PULSE_RST;
         stall_ff <= STALL_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_CLOCKS_PER_RPM: cpr_ff   <= csr_data;
            CSR_LONG_PULSE:     long_ff  <= csr_data;
            CSR_STALL:          stall_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // word and elapsed time
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff <= req_cmd;
         cap_ff <= req_capture_value;
         ovf_ff <= req_over_capture;
         now_ff <= req_now_ticks;
      end
      if (cmd.elapsed) elapsed_ff <= now_ff - last_pulse_ff;
   end

   // meter state
   always_comb begin
      prev_cap_in   = prev_cap_ff;
      last_pulse_in = last_pulse_ff;
      ptr_in        = ptr_ff;
      valid_in      = valid_ff;
      if (cmd.commit) prev_cap_in = cap_ff;
      if (store) begin
         last_pulse_in    = now_ff;
         valid_in[ptr_ff] = 1'b1;
         ptr_in = (ptr_ff == ADDR_W'(RING_DEPTH - 1)) ? '0 : ptr_ff + 1'b1;
      end
      if (cmd.clear) valid_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_cap_ff   <= '0;
         last_pulse_ff <= '0;
         ptr_ff        <= '0;
         valid_ff      <= '0;
      end else begin
         prev_cap_ff   <= prev_cap_in;
         last_pulse_ff <= last_pulse_in;
         ptr_ff        <= ptr_in;
         valid_ff      <= valid_in;
      end
   end

   // interval ring: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (store) ring_mem[ptr_ff] <= wr_data;
      if (rd_en) rd_data_ff <= ring_mem[rd_addr];
   end

   // ring sweep: read one entry a cycle, add the one read before
   always_comb begin
      idx_in    = idx_ff;
      rd_hit_in = rd_hit_ff;
      acc_in    = acc_ff;
      count_in  = count_ff;
      if (cmd.sum_start) begin
         idx_in    = '0;
         rd_hit_in = 1'b0;
         acc_in    = '0;
         count_in  = '0;
      end else if (cmd.sum_step) begin
         if (!status.sum_last) idx_in = idx_ff + 1'b1;
         rd_hit_in = rd_en && valid_ff[rd_addr];
         if (rd_hit_ff && (rd_data_ff != '0)) begin
            acc_in   = acc_ff + SUM_W'(rd_data_ff);
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff    <= '0;
         rd_hit_ff <= 1'b0;
      end else begin
         idx_ff    <= idx_in;
         rd_hit_ff <= rd_hit_in;
      end
      acc_ff   <= acc_in;
      count_ff <= count_in;
   end

   // dividend load, then restoring divide one quotient bit a cycle
   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      if (cmd.mul) begin
         quo_in  = PROD_W'(cpr_ff) * PROD_W'(count_ff);
         rem_in  = '0;
         step_in = '0;
      end else if (cmd.div_step) begin
         rem_in  = ge ? trial[SUM_W-1:0] : shifted[SUM_W-1:0];
         quo_in  = {quo_ff[PROD_W-2:0], ge};
         if (!status.div_last) step_in = step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   // result register
   always_comb begin
      rpm_in     = rpm_ff;
      stalled_in = stalled_ff;
      if (cmd.result_load) begin
         rpm_in     = '0;
         stalled_in = 1'b0;
         priority if (cmd_ff == CMD_CAPTURE) begin
            rpm_in = '0;
         end else if (over_stall) begin
            stalled_in = 1'b1;
         end else if (acc_ff == '0) begin
            rpm_in = '0;
         end else if (quo_ff[PROD_W-1:RPM_W] != '0) begin
            rpm_in = '1;
         end else begin
            rpm_in = quo_ff[RPM_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      rpm_ff     <= rpm_in;
      stalled_ff <= stalled_in;
   end

endmodule

`default_nettype wire

[hdl/fan_tach_rpm_meter.sv]
// Top level of the fan tachometer speed meter.
`default_nettype none

// Fan speed meter fed by tachometer edge captures. A capture word (cmd 0)
// stores the 16-bit wrapping interval since the previous capture into a ring
// of RING_DEPTH entries, or 0 when more than long_pulse_ticks have gone by
// since the last pulse; an overcaptured word only updates the previous
// capture. A read word (cmd 1) returns rpm = clocks_per_rpm * (nonzero
// entries) / (their sum), or 0 with stalled set when no pulse came within
// stall_ticks, which also empties the ring. Every word gives one result word;
// capture words answer rpm 0, stalled 0. Timing: the block works on one word
// at a time. A capture word, and a read that finds the fan stalled, pass the
// elapsed, check and finish states. A normal read also sweeps the ring
// through its single read port one entry a cycle, forms the dividend, and a
// restoring divider then produces one quotient bit a cycle. The result sits
// in an output register, so a new word is accepted while the last result is
// still waiting to be taken. Register writes are taken every cycle; write
// them only while the meter is idle. Ring entries come out of reset empty
// through per-entry valid bits, so no clearing pass is needed.
module fan_tach_rpm_meter import ftrm_pkg::*; #(
   parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   ftrm_req_if.sink   req_chan,
   ftrm_rsp_if.source rsp_chan,
   ftrm_csr_if.sink   csr_chan
);

   ftrm_cmd_type    dp_cmd;
   ftrm_status_type dp_status;
   logic            csr_write;

   // register writes never stall
   assign csr_chan.ready = 1'b1;
   assign csr_write      = csr_chan.valid;

   // sequence each word through the datapath
   ftrm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   // hold config, ring, sweep adder, divider and the result register
   ftrm_dpath #(
      .RING_DEPTH (RING_DEPTH)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (dp_cmd),
      .status            (dp_status),
      .req_cmd           (req_chan.cmd),
      .req_capture_value (req_chan.capture_value),
      .req_over_capture  (req_chan.over_capture),
      .req_now_ticks     (req_chan.now_ticks),
      .csr_write         (csr_write),
      .csr_index         (csr_chan.index),
      .csr_data          (csr_chan.data),
      .rsp_rpm           (rsp_chan.rpm),
      .rsp_stalled       (rsp_chan.stalled)
   );

endmodule

`default_nettype wire
